### sv/gps_pkg.sv
// Shared types, constants and fixed-point helpers for the grid particle stepper.
package gps_pkg;

	localparam int IDX_W  = 9;
	localparam int COL_W  = 16;
	localparam int SPD_W  = 9;
	localparam int ACC_W  = 13;
	localparam int DT_W   = 16;
	localparam int PIX_W  = 6;
	localparam int POS_W  = 17;
	localparam int VEL_W  = 17;
	localparam int K_W    = 29;
	localparam int PROD_W = 43;
	localparam int SUM_W  = 20;
	localparam int MV_W   = 34;
	localparam int NX_W   = 22;
	localparam int TC_W   = 12;
	localparam int FRAC_W = 10;

	localparam logic signed [SUM_W-1:0] VEL_LIMIT = 20'sd25600;

	// one particle table entry
	typedef struct packed {
		logic signed [POS_W-1:0] px;
		logic signed [POS_W-1:0] py;
		logic signed [VEL_W-1:0] vx;
		logic signed [VEL_W-1:0] vy;
		logic [COL_W-1:0]        color;
		logic [SPD_W-1:0]        speed;
		logic                    live;
	} particle_t;

	localparam int ENT_W = $bits(particle_t);

	// shift right with rounding to nearest, ties away from zero
	function automatic logic signed [47:0] rnd_shift(input logic signed [47:0] v, input int sh);
		logic [47:0] mag;
		logic [47:0] r;
		mag = v[47] ? 48'(-v) : 48'(v);
		r = (mag + (48'd1 << (sh - 1))) >> sh;
		return v[47] ? -$signed(r) : $signed(r);
	endfunction

	// cell index of a Q.10 position, truncated toward zero
	function automatic logic signed [TC_W-1:0] trunc_cell(input logic signed [NX_W-1:0] v);
		logic signed [NX_W-1:0] t;
		t = v + (v[NX_W-1] ? NX_W'(1023) : NX_W'(0));
		return t[NX_W-1:FRAC_W];
	endfunction

	// saturate a velocity sum to the speed limit
	function automatic logic signed [VEL_W-1:0] clamp_vel(input logic signed [SUM_W-1:0] v);
		if (v > VEL_LIMIT) begin
			return VEL_W'(VEL_LIMIT);
		end else if (v < -VEL_LIMIT) begin
			return VEL_W'(-VEL_LIMIT);
		end
		return v[VEL_W-1:0];
	endfunction

	// halve, truncating toward zero
	function automatic logic signed [VEL_W-1:0] halve(input logic signed [VEL_W-1:0] v);
		logic signed [VEL_W-1:0] t;
		t = v + VEL_W'(v[VEL_W-1]);
		return t >>> 1;
	endfunction

endpackage

### sv/gps_in_if.sv
// Input item channel: valid/ready with one particle command.
interface gps_in_if;
	logic                            valid;
	logic                            ready;
	logic                            func;
	logic [gps_pkg::IDX_W-1:0]       particle_index;
	logic [gps_pkg::COL_W-1:0]       load_color;
	logic [gps_pkg::SPD_W-1:0]       load_speed;
	logic signed [gps_pkg::ACC_W-1:0] accel_x;
	logic signed [gps_pkg::ACC_W-1:0] accel_y;
	logic [gps_pkg::DT_W-1:0]        time_step;

	modport source(output valid, func, particle_index, load_color, load_speed, accel_x,
		accel_y, time_step, input ready);
	modport sink(input valid, func, particle_index, load_color, load_speed, accel_x,
		accel_y, time_step, output ready);
endinterface

### sv/gps_out_if.sv
// Result channel: valid/ready with one pixel draw.
interface gps_out_if;
	logic                      valid;
	logic                      ready;
	logic [gps_pkg::PIX_W-1:0] pixel_x;
	logic [gps_pkg::PIX_W-1:0] pixel_y;
	logic [gps_pkg::COL_W-1:0] pixel_color;
	logic                      blocked;

	modport source(output valid, pixel_x, pixel_y, pixel_color, blocked, input ready);
	modport sink(input valid, pixel_x, pixel_y, pixel_color, blocked, output ready);
endinterface

### sv/grid_particle_step_top.sv
// Grid particle stepper: particle table and cell map in RAM, sequenced read-modify-write.
//
//  channel | dir | signals
//  item    | in  | func, particle_index, load_color, load_speed, accel_x, accel_y, time_step
//  pixel   | out | pixel_x, pixel_y, pixel_color, blocked
//
// A load runs from acceptance through the particle read, the old-cell clear and the
// new-cell set; an update (ending after the position add for an unloaded particle) runs
// the particle read, two multiply stages, position add, cell-map read and two writes
// on the cell map's single write port. After reset a clearing pass over max(PARTICLES,
// GRID_SIZE*GRID_SIZE) addresses zeroes both memories; no item is taken until it ends.
// A stalled pixel transaction holds only the final update cycle; new items are
// accepted while a draw waits in the output register.
module grid_particle_step_top #(
	parameter int PARTICLES = 320,
	parameter int GRID_SIZE = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	gps_in_if.sink     item,
	gps_out_if.source  pixel
);
	localparam int PA_W  = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
	localparam int CELLS = GRID_SIZE * GRID_SIZE;
	localparam int CA_W  = $clog2(CELLS);
	localparam int CW    = $clog2(GRID_SIZE);
	localparam int RECIP = (1 << 24) / GRID_SIZE;
	localparam int CLR_N = (PARTICLES > CELLS) ? PARTICLES : CELLS;
	localparam int CLR_W = $clog2(CLR_N + 1);

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_READ  = 4'd2;
	localparam logic [3:0] ST_LCLR  = 4'd3;
	localparam logic [3:0] ST_LSET  = 4'd4;
	localparam logic [3:0] ST_MULA  = 4'd5;
	localparam logic [3:0] ST_VEL   = 4'd6;
	localparam logic [3:0] ST_MULV  = 4'd7;
	localparam logic [3:0] ST_POS   = 4'd8;
	localparam logic [3:0] ST_CRD   = 4'd9;
	localparam logic [3:0] ST_CHK   = 4'd10;
	localparam logic [3:0] ST_SET   = 4'd11;

	logic [3:0]       state_q;
	logic [CLR_W-1:0] clr_q;

	logic                                  func_q;
	logic [gps_pkg::IDX_W-1:0]             idx_q;
	logic [gps_pkg::COL_W-1:0]             col_q;
	logic [gps_pkg::SPD_W-1:0]             spd_q;
	logic signed [gps_pkg::ACC_W-1:0]      ax_q, ay_q;
	logic [gps_pkg::DT_W-1:0]              dt_q;
	logic [gps_pkg::IDX_W-1:0]             q0_q;
	logic [gps_pkg::IDX_W-1:0]             ld_cx_q, ld_cy_q;
	gps_pkg::particle_t                    ent_q;
	logic [gps_pkg::K_W-1:0]               k_q;
	logic signed [gps_pkg::PROD_W-1:0]     prx_q, pry_q;
	logic signed [gps_pkg::VEL_W-1:0]      vx_q, vy_q;
	logic signed [gps_pkg::MV_W-1:0]       mx_q, my_q;
	logic signed [gps_pkg::TC_W-1:0]       tx_q, ty_q;
	logic signed [gps_pkg::POS_W-1:0]      nx_q, ny_q;
	logic                                  off_q, own_q, blk_q;
	logic [CA_W-1:0]                       tcell_q;

	logic                      pv_q, pblk_q;
	logic [gps_pkg::PIX_W-1:0] ppx_q, ppy_q;
	logic [gps_pkg::COL_W-1:0] pcol_q;

	// memory ports
	logic                      p_we;
	logic [PA_W-1:0]           p_waddr, p_raddr;
	gps_pkg::particle_t        p_wdata, p_rdata;
	logic                      c_we;
	logic [CA_W-1:0]           c_waddr, c_raddr;
	logic                      c_wdata, c_rdata;

	gps_ram #(.WIDTH(gps_pkg::ENT_W), .DEPTH(PARTICLES)) u_part (
		.clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
		.raddr(p_raddr), .rdata(p_rdata)
	);

	gps_ram #(.WIDTH(1), .DEPTH(CELLS)) u_cell (
		.clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
		.raddr(c_raddr), .rdata(c_rdata)
	);

	// handshake
	logic acc, in_range, out_free;
	assign item.ready = (state_q == ST_IDLE);
	assign acc        = item.valid && item.ready;
	assign in_range   = ({4'd0, item.particle_index} < 13'(PARTICLES));
	assign out_free   = !pv_q || pixel.ready;
	assign p_raddr    = PA_W'(item.particle_index);
	assign c_raddr    = tcell_q;

	// old cell of the particle
	logic signed [gps_pkg::TC_W-1:0] old_cx, old_cy;
	logic                            old_on;
	logic [CA_W-1:0]                 old_addr;
	assign old_cx = gps_pkg::trunc_cell(gps_pkg::NX_W'(ent_q.px));
	assign old_cy = gps_pkg::trunc_cell(gps_pkg::NX_W'(ent_q.py));
	assign old_on = !old_cx[gps_pkg::TC_W-1] && (old_cx[gps_pkg::TC_W-2:0] < 11'(GRID_SIZE)) &&
		!old_cy[gps_pkg::TC_W-1] && (old_cy[gps_pkg::TC_W-2:0] < 11'(GRID_SIZE));
	assign old_addr = CA_W'(old_cy[CW-1:0]) * CA_W'(GRID_SIZE) + CA_W'(old_cx[CW-1:0]);

	// load placement: row by reciprocal multiply with one correction
	logic [31:0]              q0_full;
	logic [11:0]              ld_r;
	assign q0_full = 32'(item.particle_index) * 32'(RECIP);
	assign ld_r    = 12'(idx_q) - 12'(q0_q) * 12'(GRID_SIZE);

	// target position
	logic signed [47:0]               dpx, dpy;
	logic signed [gps_pkg::NX_W-1:0]  nxf, nyf;
	logic signed [gps_pkg::TC_W-1:0]  txf, tyf;
	logic                             t_on;
	assign dpx = gps_pkg::rnd_shift(48'(mx_q), 14);
	assign dpy = gps_pkg::rnd_shift(48'(my_q), 14);
	assign nxf = gps_pkg::NX_W'(ent_q.px) + dpx[gps_pkg::NX_W-1:0];
	assign nyf = gps_pkg::NX_W'(ent_q.py) + dpy[gps_pkg::NX_W-1:0];
	assign txf = gps_pkg::trunc_cell(nxf);
	assign tyf = gps_pkg::trunc_cell(nyf);
	assign t_on = !txf[gps_pkg::TC_W-1] && (txf[gps_pkg::TC_W-2:0] < 11'(GRID_SIZE)) &&
		!tyf[gps_pkg::TC_W-1] && (tyf[gps_pkg::TC_W-2:0] < 11'(GRID_SIZE));

	// velocity sums
	logic signed [47:0] dvx, dvy;
	assign dvx = gps_pkg::rnd_shift(48'(prx_q), 24);
	assign dvy = gps_pkg::rnd_shift(48'(pry_q), 24);

	logic blk_now;
	assign blk_now = off_q || (!own_q && c_rdata);

	// memory write selection
	always_comb begin
		p_we    = 1'b0;
		p_waddr = PA_W'(idx_q);
		p_wdata = ent_q;
		c_we    = 1'b0;
		c_waddr = old_addr;
		c_wdata = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				p_we    = (clr_q < CLR_W'(PARTICLES));
				p_waddr = PA_W'(clr_q);
				p_wdata = '0;
				c_we    = (clr_q < CLR_W'(CELLS));
				c_waddr = CA_W'(clr_q);
			end
			ST_LCLR: begin
				p_we          = 1'b1;
				p_wdata.px    = gps_pkg::POS_W'({ld_cx_q, 10'd0});
				p_wdata.py    = gps_pkg::POS_W'({ld_cy_q, 10'd0});
				p_wdata.vx    = '0;
				p_wdata.vy    = '0;
				p_wdata.color = col_q;
				p_wdata.speed = spd_q;
				p_wdata.live  = 1'b1;
				c_we          = ent_q.live && old_on;
			end
			ST_LSET: begin
				c_we    = (ld_cy_q < gps_pkg::IDX_W'(GRID_SIZE));
				c_waddr = CA_W'(ld_cy_q) * CA_W'(GRID_SIZE) + CA_W'(ld_cx_q);
				c_wdata = 1'b1;
			end
			ST_POS: begin
				p_we       = !ent_q.live;
				p_wdata.vx = vx_q;
				p_wdata.vy = vy_q;
			end
			ST_CHK: begin
				p_we       = 1'b1;
				p_wdata.px = blk_now ? ent_q.px : nx_q;
				p_wdata.py = blk_now ? ent_q.py : ny_q;
				p_wdata.vx = blk_now ? gps_pkg::halve(vx_q) : vx_q;
				p_wdata.vy = blk_now ? gps_pkg::halve(vy_q) : vy_q;
				c_we       = !blk_now && old_on;
			end
			ST_SET: begin
				c_we    = out_free && !blk_q;
				c_waddr = tcell_q;
				c_wdata = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_W'(CLR_N - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE:  if (acc && in_range) state_q <= ST_READ;
				ST_READ:  state_q <= func_q ? ST_MULA : ST_LCLR;
				ST_LCLR:  state_q <= ST_LSET;
				ST_LSET:  state_q <= ST_IDLE;
				ST_MULA:  state_q <= ST_VEL;
				ST_VEL:   state_q <= ST_MULV;
				ST_MULV:  state_q <= ST_POS;
				ST_POS:   state_q <= ent_q.live ? ST_CRD : ST_IDLE;
				ST_CRD:   state_q <= ST_CHK;
				ST_CHK:   state_q <= ST_SET;
				ST_SET:   if (out_free) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (acc) begin
			func_q <= item.func;
			idx_q  <= item.particle_index;
			col_q  <= item.load_color;
			spd_q  <= item.load_speed;
			ax_q   <= item.accel_x;
			ay_q   <= item.accel_y;
			dt_q   <= item.time_step;
			q0_q   <= gps_pkg::IDX_W'(q0_full >> 24);
		end
		if (state_q == ST_READ) begin
			ent_q <= p_rdata;
			k_q   <= gps_pkg::K_W'(p_rdata.speed) * gps_pkg::K_W'(dt_q) * gps_pkg::K_W'(10);
			if (ld_r >= 12'(GRID_SIZE)) begin
				ld_cx_q <= gps_pkg::IDX_W'(ld_r - 12'(GRID_SIZE));
				ld_cy_q <= q0_q + 1'b1;
			end else begin
				ld_cx_q <= gps_pkg::IDX_W'(ld_r);
				ld_cy_q <= q0_q;
			end
		end
		if (state_q == ST_MULA) begin
			prx_q <= gps_pkg::PROD_W'(ax_q) * $signed({1'b0, k_q});
			pry_q <= gps_pkg::PROD_W'(ay_q) * $signed({1'b0, k_q});
		end
		if (state_q == ST_VEL) begin
			vx_q <= gps_pkg::clamp_vel(gps_pkg::SUM_W'(ent_q.vx) + dvx[gps_pkg::SUM_W-1:0]);
			vy_q <= gps_pkg::clamp_vel(gps_pkg::SUM_W'(ent_q.vy) + dvy[gps_pkg::SUM_W-1:0]);
		end
		if (state_q == ST_MULV) begin
			mx_q <= gps_pkg::MV_W'(vx_q) * $signed({1'b0, dt_q});
			my_q <= gps_pkg::MV_W'(vy_q) * $signed({1'b0, dt_q});
		end
		if (state_q == ST_POS) begin
			nx_q    <= nxf[gps_pkg::POS_W-1:0];
			ny_q    <= nyf[gps_pkg::POS_W-1:0];
			tx_q    <= txf;
			ty_q    <= tyf;
			off_q   <= !t_on;
			own_q   <= (txf == old_cx) && (tyf == old_cy);
			tcell_q <= CA_W'(tyf[CW-1:0]) * CA_W'(GRID_SIZE) + CA_W'(txf[CW-1:0]);
		end
		if (state_q == ST_CHK) begin
			blk_q <= blk_now;
		end
	end

	// pixel output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q <= 1'b0;
		end else if (state_q == ST_SET && out_free) begin
			pv_q <= 1'b1;
		end else if (pixel.ready) begin
			pv_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SET && out_free) begin
			ppx_q  <= blk_q ? old_cx[gps_pkg::PIX_W-1:0] : tx_q[gps_pkg::PIX_W-1:0];
			ppy_q  <= blk_q ? old_cy[gps_pkg::PIX_W-1:0] : ty_q[gps_pkg::PIX_W-1:0];
			pcol_q <= ent_q.color;
			pblk_q <= blk_q;
		end
	end

	assign pixel.valid       = pv_q;
	assign pixel.pixel_x     = ppx_q;
	assign pixel.pixel_y     = ppy_q;
	assign pixel.pixel_color = pcol_q;
	assign pixel.blocked     = pblk_q;

`ifndef NO_ASSERTIONS
	// an accepted in-range item starts with the particle read
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		acc && in_range |=> state_q == ST_READ)
		else $error("accepted item did not start a read");

	// memories are quiet while waiting for an item
	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !p_we && !c_we)
		else $error("memory write while idle");

	// a draw is only produced by the final update step
	a_draw: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pv_q) |-> $past(state_q) == ST_SET)
		else $error("pixel draw without an update");

	// nothing is drawn during the clearing pass
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !pv_q)
		else $error("pixel draw during clearing pass");
`endif
endmodule

### sv/gps_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
module gps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  logic [WIDTH-1:0]      wdata,
	input  logic [AW-1:0]         raddr,
	output logic [WIDTH-1:0]      rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

### tb/sv/grid_particle_step_top_tb.sv
// Self-checking testbench for the grid particle stepper: bit-true predictor, random traffic.
module grid_particle_step_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NPART = 320;
	localparam int GRID = 64;
	localparam int POS_UNIT = 1024;
	localparam longint SPEED_CAP = 25600;
	localparam int RANDOM_ITEMS = 712;
	localparam int TAIL_ITEMS = 120;
	localparam int LONG_HOLD = 400;
	localparam int DRAIN_CYCLES = 30;
	localparam int CYCLE_LIMIT = 400000;

	typedef enum bit {OP_LOAD = 1'b0, OP_UPDATE = 1'b1} op_t;

	typedef struct {
		op_t                                op;
		logic [gps_pkg::IDX_W-1:0]          idx;
		logic [gps_pkg::COL_W-1:0]          color;
		logic [gps_pkg::SPD_W-1:0]          speed;
		logic signed [gps_pkg::ACC_W-1:0]   ax;
		logic signed [gps_pkg::ACC_W-1:0]   ay;
		logic [gps_pkg::DT_W-1:0]           dt;
	} cmd_t;

	typedef struct {
		logic [gps_pkg::PIX_W-1:0] x;
		logic [gps_pkg::PIX_W-1:0] y;
		logic [gps_pkg::COL_W-1:0] color;
		logic                      blocked;
	} draw_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	gps_in_if item_if();
	gps_out_if pixel_if();

	grid_particle_step_top #(.PARTICLES(NPART), .GRID_SIZE(GRID)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_if),
		.pixel(pixel_if)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// particle table mirror
	longint pos_x[NPART], pos_y[NPART], vel_x[NPART], vel_y[NPART];
	bit [gps_pkg::COL_W-1:0] part_color[NPART];
	bit [gps_pkg::SPD_W-1:0] part_speed[NPART];
	bit part_live[NPART];
	bit cell_busy[GRID*GRID];

	cmd_t pending_cmds[$];
	draw_t expected_draws[$];
	int errors = 0;
	int draws_seen = 0;
	int cycles = 0;
	bit tail_phase = 1'b0;
	bit item_taken = 1'b0;

	task automatic report(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d (draw %0d)", what, got, want, draws_seen);
		errors++;
	endtask

	// round to nearest, ties away from zero
	function automatic longint round_shr(longint v, int sh);
		longint mag;
		mag = v < 0 ? -v : v;
		mag = (mag + (longint'(1) << (sh - 1))) >>> sh;
		return v < 0 ? -mag : mag;
	endfunction

	function automatic longint sat_speed(longint v);
		if (v > SPEED_CAP) return SPEED_CAP;
		if (v < -SPEED_CAP) return -SPEED_CAP;
		return v;
	endfunction

	function automatic bit in_grid(longint cx, longint cy);
		return cx >= 0 && cx < GRID && cy >= 0 && cy < GRID;
	endfunction

	// apply one accepted transaction to the mirror and queue any draw
	task automatic predict_step(cmd_t c);
		int i;
		longint cx, cy, k, nx, ny, tx, ty;
		bit blk;
		draw_t d;
		if (c.idx >= NPART) return;
		i = int'(c.idx);
		cx = pos_x[i] / POS_UNIT;
		cy = pos_y[i] / POS_UNIT;
		if (c.op == OP_LOAD) begin
			if (part_live[i] && in_grid(cx, cy)) cell_busy[cy*GRID + cx] = 1'b0;
			cx = longint'(i % GRID);
			cy = longint'(i / GRID);
			pos_x[i] = cx * POS_UNIT;
			pos_y[i] = cy * POS_UNIT;
			vel_x[i] = 0;
			vel_y[i] = 0;
			part_color[i] = c.color;
			part_speed[i] = c.speed;
			part_live[i] = 1'b1;
			if (in_grid(cx, cy)) cell_busy[cy*GRID + cx] = 1'b1;
			return;
		end
		k = longint'(part_speed[i]) * longint'(c.dt) * 10;
		vel_x[i] = sat_speed(vel_x[i] + round_shr(longint'(c.ax) * k, 24));
		vel_y[i] = sat_speed(vel_y[i] + round_shr(longint'(c.ay) * k, 24));
		if (!part_live[i]) return;
		nx = pos_x[i] + round_shr(vel_x[i] * longint'(c.dt), 14);
		ny = pos_y[i] + round_shr(vel_y[i] * longint'(c.dt), 14);
		tx = nx / POS_UNIT;
		ty = ny / POS_UNIT;
		if (!in_grid(tx, ty)) blk = 1'b1;
		else if (tx == cx && ty == cy) blk = 1'b0;
		else blk = cell_busy[ty*GRID + tx];
		if (blk) begin
			vel_x[i] = vel_x[i] / 2;
			vel_y[i] = vel_y[i] / 2;
		end else begin
			if (in_grid(cx, cy)) cell_busy[cy*GRID + cx] = 1'b0;
			cell_busy[ty*GRID + tx] = 1'b1;
			pos_x[i] = nx;
			pos_y[i] = ny;
			cx = tx;
			cy = ty;
		end
		d.x = cx[gps_pkg::PIX_W-1:0];
		d.y = cy[gps_pkg::PIX_W-1:0];
		d.color = part_color[i];
		d.blocked = blk;
		expected_draws.push_back(d);
	endtask

	function automatic cmd_t make_cmd(op_t op, int idx, int ax, int ay, int dt);
		cmd_t c;
		c.op = op;
		c.idx = gps_pkg::IDX_W'(idx);
		c.color = gps_pkg::COL_W'($urandom);
		c.speed = gps_pkg::SPD_W'($urandom_range(511, 256));
		c.ax = gps_pkg::ACC_W'(ax);
		c.ay = gps_pkg::ACC_W'(ay);
		c.dt = gps_pkg::DT_W'(dt);
		return c;
	endfunction

	// random transaction: mostly updates with a spread of step sizes
	function automatic cmd_t random_cmd();
		cmd_t c;
		int pick;
		int dt;
		pick = $urandom_range(99);
		case ($urandom_range(3))
			0: dt = $urandom_range(65535);
			1: dt = $urandom_range(4000);
			default: dt = $urandom_range(20000);
		endcase
		c = make_cmd(OP_UPDATE, $urandom_range(NPART-1), $urandom_range(8191) - 4096,
			$urandom_range(8191) - 4096, dt);
		if (pick < 6) begin
			c.op = OP_LOAD;
		end else if (pick < 11) begin
			// out of range: everything is don't-care, so use full field widths
			c.idx = gps_pkg::IDX_W'($urandom_range(511, NPART));
			c.op = op_t'($urandom_range(1));
			c.speed = gps_pkg::SPD_W'($urandom);
		end
		return c;
	endfunction

	// input driver: changes at the falling edge, random bursts of idle
	int send_gap = 0;
	always @(negedge clk) begin
		if (!arst_n) begin
			item_if.valid <= 1'b0;
			item_if.func <= 1'b0;
			item_if.particle_index <= '0;
			item_if.load_color <= '0;
			item_if.load_speed <= '0;
			item_if.accel_x <= '0;
			item_if.accel_y <= '0;
			item_if.time_step <= '0;
		end else if (item_if.valid && !item_taken) begin
			// hold the offered transaction
		end else if (send_gap > 0) begin
			send_gap <= send_gap - 1;
			item_if.valid <= 1'b0;
		end else if (!tail_phase && $urandom_range(7) == 0) begin
			send_gap <= $urandom_range(16);
			item_if.valid <= 1'b0;
		end else if (pending_cmds.size() > 0) begin
			cmd_t c;
			c = pending_cmds.pop_front();
			item_if.valid <= 1'b1;
			item_if.func <= c.op;
			item_if.particle_index <= c.idx;
			item_if.load_color <= c.color;
			item_if.load_speed <= c.speed;
			item_if.accel_x <= c.ax;
			item_if.accel_y <= c.ay;
			item_if.time_step <= c.dt;
		end else begin
			item_if.valid <= 1'b0;
		end
	end

	// result receiver: random stalls plus one long hold-off to back up the block
	int stall_left = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	always @(negedge clk) begin
		if (!arst_n) begin
			pixel_if.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			pixel_if.ready <= 1'b0;
		end else if (!hold_done && draws_seen >= 60) begin
			hold_done <= 1'b1;
			hold_left <= LONG_HOLD;
			pixel_if.ready <= 1'b0;
		end else if (tail_phase) begin
			pixel_if.ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			pixel_if.ready <= 1'b0;
		end else if ($urandom_range(7) == 0) begin
			stall_left <= $urandom_range(16);
			pixel_if.ready <= 1'b0;
		end else begin
			pixel_if.ready <= 1'b1;
		end
	end

	// monitor: check draws, then feed accepted transactions to the predictor
	always @(posedge clk) begin
		item_taken <= 1'b0;
		if (arst_n) begin
			if (pixel_if.valid && pixel_if.ready) begin
				if (expected_draws.size() == 0) begin
					report("unexpected draw", pixel_if.pixel_x, -1);
				end else begin
					draw_t d;
					d = expected_draws.pop_front();
					if (pixel_if.pixel_x !== d.x) report("pixel_x", pixel_if.pixel_x, d.x);
					if (pixel_if.pixel_y !== d.y) report("pixel_y", pixel_if.pixel_y, d.y);
					if (pixel_if.pixel_color !== d.color)
						report("pixel_color", pixel_if.pixel_color, d.color);
					if (pixel_if.blocked !== d.blocked)
						report("blocked", pixel_if.blocked, d.blocked);
				end
				draws_seen <= draws_seen + 1;
			end
			if (item_if.valid && item_if.ready) begin
				cmd_t c;
				c.op = op_t'(item_if.func);
				c.idx = item_if.particle_index;
				c.color = item_if.load_color;
				c.speed = item_if.load_speed;
				c.ax = item_if.accel_x;
				c.ay = item_if.accel_y;
				c.dt = item_if.time_step;
				predict_step(c);
				item_taken <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// stimulus and end of run
	initial begin
		int order[NPART];
		for (int i = 0; i < NPART; i++) begin
			pos_x[i] = 0; pos_y[i] = 0; vel_x[i] = 0; vel_y[i] = 0;
			part_color[i] = 0; part_speed[i] = 0; part_live[i] = 0;
		end
		foreach (cell_busy[j]) cell_busy[j] = 1'b0;

		// load every particle, in shuffled order
		foreach (order[i]) order[i] = i;
		order.shuffle();
		foreach (order[i]) pending_cmds.push_back(make_cmd(OP_LOAD, order[i], 0, 0, 0));

		// directed: small negative step stays in cell 0
		pending_cmds.push_back(make_cmd(OP_UPDATE, 0, -4096, 0, 1000));
		pending_cmds.push_back(make_cmd(OP_UPDATE, 0, 0, -4096, 1000));
		// step into a held cell further along row 0
		pending_cmds.push_back(make_cmd(OP_UPDATE, 1, 4095, 0, 30000));
		pending_cmds.push_back(make_cmd(OP_UPDATE, 1, 4095, 0, 30000));
		// off the grid on each side, extreme accel and time step
		pending_cmds.push_back(make_cmd(OP_UPDATE, 2, 0, -4096, 65535));
		pending_cmds.push_back(make_cmd(OP_UPDATE, 319, 4095, 4095, 65535));
		pending_cmds.push_back(make_cmd(OP_UPDATE, 319, -4096, -4096, 65535));
		pending_cmds.push_back(make_cmd(OP_UPDATE, 63, 4095, 0, 65535));
		pending_cmds.push_back(make_cmd(OP_UPDATE, 256, -4096, 4095, 65535));
		// zero time step, zero accel
		pending_cmds.push_back(make_cmd(OP_UPDATE, 100, 4095, -4096, 0));
		pending_cmds.push_back(make_cmd(OP_UPDATE, 101, 0, 0, 65535));
		// free interior move into an empty cell
		pending_cmds.push_back(make_cmd(OP_UPDATE, 200, 2000, 2000, 20000));
		// reload after a move, and reload on top of a moved-in particle
		pending_cmds.push_back(make_cmd(OP_LOAD, 319, 0, 0, 0));
		pending_cmds.push_back(make_cmd(OP_LOAD, 0, 0, 0, 0));
		pending_cmds.push_back(make_cmd(OP_UPDATE, 0, 4095, 4095, 8000));
		// out of range indices do nothing
		pending_cmds.push_back(make_cmd(OP_UPDATE, 320, 4095, 4095, 65535));
		pending_cmds.push_back(make_cmd(OP_LOAD, 511, 0, 0, 0));
		pending_cmds.push_back(make_cmd(OP_UPDATE, 511, -4096, -4096, 65535));

		for (int n = 0; n < RANDOM_ITEMS; n++) pending_cmds.push_back(random_cmd());

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (pending_cmds.size() < TAIL_ITEMS);
		tail_phase = 1'b1;
		wait (pending_cmds.size() == 0);
		@(posedge clk);
		while (item_if.valid || expected_draws.size() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && expected_draws.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule
